@@ src/line_rasterizer_core_assert.svh @@
// Assertion macros for the line rasterizer core.
// All checks are sampled on i_clk and are off while i_rst_n is low.
`ifndef LINE_RASTERIZER_CORE_ASSERT_SVH
`define LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lr_pkg.sv @@
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS  = 6;
    localparam int COLOUR_BITS = 8;
    // Decision term: |d| stays below 2 * 2^COORD_BITS, plus sign and margin.
    localparam int D_BITS      = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0]         t_coord;
    typedef logic [COLOUR_BITS-1:0]        t_colour;
    typedef logic signed [D_BITS-1:0]      t_dterm;

    // One classified line, ready for the stepper.
    typedef struct packed {
        t_coord  x0;
        t_coord  y0;
        logic    x_neg;        // x moves down
        logic    y_neg;        // y moves down
        logic    x_major;
        logic    major_rises;  // tie rule: axis step when set
        t_coord  steps;        // major-axis length, pixels minus one
        t_dterm  d0;           // 2B - A
        t_dterm  inc_axis;     // 2B
        t_dterm  inc_diag;     // 2B - 2A
        t_colour colour;
    } t_line_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

`default_nettype wire

@@ src/lr_front.sv @@
`default_nettype none

module lr_front
    import lr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_coord      i_start_x,
    input  wire t_coord      i_start_y,
    input  wire t_coord      i_end_x,
    input  wire t_coord      i_end_y,
    input  wire t_colour     i_colour,
    input  wire t_queue_stat i_q_stat,
    output logic             o_push,
    output t_line_desc       o_desc
);

    logic                  r_valid;
    logic                  n_valid;
    t_line_desc            r_desc;
    t_line_desc            w_desc;
    logic                  w_accept;
    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    t_coord                w_adx;
    t_coord                w_ady;
    t_coord                w_a;
    t_coord                w_b;

    assign o_push   = r_valid && !i_q_stat.full;
    assign busy     = r_valid && i_q_stat.full;
    assign w_accept = start && !busy;
    assign o_desc   = r_desc;

    assign w_dx  = $signed({1'b0, i_end_x}) - $signed({1'b0, i_start_x});
    assign w_dy  = $signed({1'b0, i_end_y}) - $signed({1'b0, i_start_y});
    assign w_adx = w_dx[COORD_BITS] ? t_coord'(-w_dx) : w_dx[COORD_BITS-1:0];
    assign w_ady = w_dy[COORD_BITS] ? t_coord'(-w_dy) : w_dy[COORD_BITS-1:0];

    // Classify: flat lines run low to high with B = 0, others per octant.
    always_comb begin
        w_desc        = '0;
        w_desc.colour = i_colour;
        w_a           = '0;
        w_b           = '0;
        priority if (w_dy == '0) begin
            w_desc.x0          = w_dx[COORD_BITS] ? i_end_x : i_start_x;
            w_desc.y0          = i_start_y;
            w_desc.x_major     = 1'b1;
            w_desc.major_rises = 1'b1;
            w_a                = w_adx;
        end else if (w_dx == '0) begin
            w_desc.x0          = i_start_x;
            w_desc.y0          = w_dy[COORD_BITS] ? i_end_y : i_start_y;
            w_desc.x_major     = 1'b0;
            w_desc.major_rises = 1'b1;
            w_a                = w_ady;
        end else begin
            w_desc.x0          = i_start_x;
            w_desc.y0          = i_start_y;
            w_desc.x_neg       = w_dx[COORD_BITS];
            w_desc.y_neg       = w_dy[COORD_BITS];
            w_desc.x_major     = (w_adx >= w_ady);
            w_desc.major_rises = (w_adx >= w_ady) ? !w_dx[COORD_BITS] : !w_dy[COORD_BITS];
            w_a                = (w_adx >= w_ady) ? w_adx : w_ady;
            w_b                = (w_adx >= w_ady) ? w_ady : w_adx;
        end
        w_desc.steps    = w_a;
        w_desc.inc_axis = $signed({2'b00, w_b, 1'b0});
        w_desc.d0       = $signed({2'b00, w_b, 1'b0}) - $signed({3'b000, w_a});
        w_desc.inc_diag = $signed({2'b00, w_b, 1'b0}) - $signed({2'b00, w_a, 1'b0});
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_desc <= w_desc;
        end
    end

endmodule

`default_nettype wire

@@ src/lr_queue.sv @@
`default_nettype none

module lr_queue
    import lr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_line_desc i_desc,
    input  wire logic       i_pop,
    output t_line_desc      o_desc,
    output t_queue_stat     o_stat
);

    t_line_desc              r_mem [QUEUE_DEPTH];
    logic [Q_PTR_BITS-1:0]   r_wr_ptr;
    logic [Q_PTR_BITS-1:0]   r_rd_ptr;
    logic [Q_CNT_BITS-1:0]   r_count;
    logic                    w_push;
    logic                    w_pop;

    assign o_stat.full  = (r_count == Q_CNT_BITS'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_desc       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

`default_nettype wire

@@ src/lr_back.sv @@
`default_nettype none

module lr_back
    import lr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_queue_stat i_q_stat,
    input  wire t_line_desc  i_desc,
    output logic             o_pop,
    output logic             o_pixel_valid,
    output t_coord           o_pixel_x,
    output t_coord           o_pixel_y,
    output t_colour          o_pixel_colour,
    output logic             o_last_pixel
);

    logic    r_active;
    logic    r_out_valid;
    t_coord  r_x;
    t_coord  r_y;
    t_dterm  r_d;
    t_coord  r_cnt;
    logic    r_x_neg;
    logic    r_y_neg;
    logic    r_x_major;
    logic    r_rises;
    t_dterm  r_inc_axis;
    t_dterm  r_inc_diag;
    t_colour r_colour;
    t_coord  r_out_x;
    t_coord  r_out_y;
    t_colour r_out_colour;
    logic    r_out_last;

    logic    w_last;
    logic    w_diag;
    logic    w_step_x;
    logic    w_step_y;
    t_dterm  w_d_next;
    t_coord  w_x_next;
    t_coord  w_y_next;

    assign w_last = (r_cnt == '0);
    assign o_pop  = !i_q_stat.empty && (!r_active || w_last);

    // Midpoint step; a zero term goes diagonal only when the major axis falls.
    always_comb begin
        w_diag   = (r_d > 0) || (!r_rises && (r_d == '0));
        w_d_next = w_diag ? r_d + r_inc_diag : r_d + r_inc_axis;
        w_step_x = r_x_major || w_diag;
        w_step_y = !r_x_major || w_diag;
        w_x_next = r_x;
        w_y_next = r_y;
        if (w_step_x) begin
            w_x_next = r_x_neg ? r_x - 1'b1 : r_x + 1'b1;
        end
        if (w_step_y) begin
            w_y_next = r_y_neg ? r_y - 1'b1 : r_y + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (r_active && w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_out_x      <= r_x;
            r_out_y      <= r_y;
            r_out_colour <= r_colour;
            r_out_last   <= w_last;
        end
        if (o_pop) begin
            r_x        <= i_desc.x0;
            r_y        <= i_desc.y0;
            r_d        <= i_desc.d0;
            r_cnt      <= i_desc.steps;
            r_x_neg    <= i_desc.x_neg;
            r_y_neg    <= i_desc.y_neg;
            r_x_major  <= i_desc.x_major;
            r_rises    <= i_desc.major_rises;
            r_inc_axis <= i_desc.inc_axis;
            r_inc_diag <= i_desc.inc_diag;
            r_colour   <= i_desc.colour;
        end else if (r_active) begin
            r_x   <= w_x_next;
            r_y   <= w_y_next;
            r_d   <= w_d_next;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_pixel_valid  = r_out_valid;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_pixel_colour = r_out_colour;
    assign o_last_pixel   = r_out_last;

endmodule

`default_nettype wire

@@ src/line_rasterizer_core.sv @@
`default_nettype none
// Channel   Direction  Handshake                Beat
// command   in         start & !busy            i_start_x/y, i_end_x/y, i_colour
// pixel     out        o_pixel_valid (strobe)   o_pixel_x/y, o_pixel_colour, o_last_pixel
//
// A line of N = max(|dx|,|dy|)+1 pixels streams one pixel per cycle from the stepper;
// a command beat passes the command register, queue, stepper and output register.
// Lines queued behind a running line follow it with no gap cycles.
// Reset (i_rst_n low, synchronous) drops every queued and running line.
// The pixel side cannot stall; busy rises only when the command register and
// the two-entry line queue are all occupied.

`include "line_rasterizer_core_assert.svh"

module line_rasterizer_core
    import lr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_coord  i_start_x,
    input  wire t_coord  i_start_y,
    input  wire t_coord  i_end_x,
    input  wire t_coord  i_end_y,
    input  wire t_colour i_colour,
    output logic         o_pixel_valid,
    output t_coord       o_pixel_x,
    output t_coord       o_pixel_y,
    output t_colour      o_pixel_colour,
    output logic         o_last_pixel
);

    // Front classifies into a descriptor, queue decouples, back steps pixels.
    t_queue_stat w_q_stat;
    t_line_desc  w_push_desc;
    t_line_desc  w_pop_desc;
    logic        w_push;
    logic        w_pop;

    lr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_colour  (i_colour),
        .i_q_stat  (w_q_stat),
        .o_push    (w_push),
        .o_desc    (w_push_desc)
    );

    lr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_desc  (w_pop_desc),
        .o_stat  (w_q_stat)
    );

    lr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (w_q_stat),
        .i_desc         (w_pop_desc),
        .o_pop          (w_pop),
        .o_pixel_valid  (o_pixel_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_colour (o_pixel_colour),
        .o_last_pixel   (o_last_pixel)
    );

    // A line's pixels come in consecutive cycles.
    `LR_ASSERT_NEXT(a_line_contiguous, o_pixel_valid && !o_last_pixel, o_pixel_valid, "pixel gap inside a line")
    // Colour holds across one line.
    `LR_ASSERT_NOW(a_colour_holds, o_pixel_valid && $past(o_pixel_valid) && !$past(o_last_pixel), o_pixel_colour == $past(o_pixel_colour), "colour changed mid-line")
    // Every step inside a line moves the pixel.
    `LR_ASSERT_NOW(a_pixel_moves, o_pixel_valid && $past(o_pixel_valid) && !$past(o_last_pixel), (o_pixel_x != $past(o_pixel_x)) || (o_pixel_y != $past(o_pixel_y)), "repeated pixel in a line")

endmodule

`default_nettype wire

@@ sim/tb_line_rasterizer_core.sv @@
`timescale 1ns / 1ps

module tb_line_rasterizer_core;
    import lr_pkg::*;

    // One line command as the sender presents it.
    typedef struct {
        t_coord  sx;
        t_coord  sy;
        t_coord  ex;
        t_coord  ey;
        t_colour col;
        bit      drain_first;   // hold this beat off until every pixel has come back
    } t_line_cmd;

    // One pixel beat as the block should emit it.
    typedef struct {
        t_coord  x;
        t_coord  y;
        t_colour col;
        logic    last;
    } t_pixel;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_coord  i_start_x;
    t_coord  i_start_y;
    t_coord  i_end_x;
    t_coord  i_end_y;
    t_colour i_colour;
    logic    o_pixel_valid;
    t_coord  o_pixel_x;
    t_coord  o_pixel_y;
    t_colour o_pixel_colour;
    logic    o_last_pixel;

    t_line_cmd line_cmds[$];       // commands not yet presented
    t_line_cmd cur_cmd;            // command on the input ports
    t_pixel    pending_pixels[$];  // predicted pixels, oldest first
    int        lines_sent;
    int        error_count;

    line_rasterizer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_colour       (i_colour),
        .o_pixel_valid  (o_pixel_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_colour (o_pixel_colour),
        .o_last_pixel   (o_last_pixel)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Every input known from time zero; reset held at the start, then released once.
    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x   = '0;
        i_end_y   = '0;
        i_colour  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Pixel predictor: pushes every pixel of one line, in drawing order.
    function automatic void trace_line(input t_line_cmd c);
        int     x0, y0, x1, y1, dx, dy, lo, hi;
        int     adx, ady, a, b, sx, sy, d, x, y;
        bit     x_major, rises, diag;
        t_pixel p;
        x0 = c.sx;
        y0 = c.sy;
        x1 = c.ex;
        y1 = c.ey;
        dx = x1 - x0;
        dy = y1 - y0;
        p.col = c.col;
        if (dy == 0) begin
            // horizontal (and single point): always low x to high x
            lo = (dx < 0) ? x1 : x0;
            hi = (dx < 0) ? x0 : x1;
            for (int i = lo; i <= hi; i++) begin
                p.x    = t_coord'(i);
                p.y    = t_coord'(y0);
                p.last = (i == hi);
                pending_pixels.push_back(p);
            end
            return;
        end
        if (dx == 0) begin
            // vertical: always low y to high y
            lo = (dy < 0) ? y1 : y0;
            hi = (dy < 0) ? y0 : y1;
            for (int i = lo; i <= hi; i++) begin
                p.x    = t_coord'(x0);
                p.y    = t_coord'(i);
                p.last = (i == hi);
                pending_pixels.push_back(p);
            end
            return;
        end
        adx     = (dx < 0) ? -dx : dx;
        ady     = (dy < 0) ? -dy : dy;
        x_major = (adx >= ady);     // 45 degree lines step x
        a       = x_major ? adx : ady;
        b       = x_major ? ady : adx;
        sx      = (dx > 0) ? 1 : -1;
        sy      = (dy > 0) ? 1 : -1;
        rises   = x_major ? (dx > 0) : (dy > 0);
        d       = 2 * b - a;
        x       = x0;
        y       = y0;
        p.x     = t_coord'(x);
        p.y     = t_coord'(y);
        p.last  = 1'b0;
        pending_pixels.push_back(p);
        for (int i = 0; i < a; i++) begin
            // tie on d == 0: axis step when the major coordinate rises, diagonal when it falls
            diag = rises ? (d > 0) : (d >= 0);
            d    = diag ? d + 2 * b - 2 * a : d + 2 * b;
            if (x_major) begin
                x = x + sx;
                if (diag) y = y + sy;
            end else begin
                y = y + sy;
                if (diag) x = x + sx;
            end
            p.x    = t_coord'(x);
            p.y    = t_coord'(y);
            p.last = (i == a - 1);
            pending_pixels.push_back(p);
        end
    endfunction

    // Command driver. Sender idle rate: 16% for the first stretch, 81% for the
    // second, then back to back.
    always @(posedge i_clk) begin : drive_cmds
        bit taken;
        bit launch;
        int idle_pct;
        taken    = start && !busy;
        idle_pct = (lines_sent < 100) ? 16 : (lines_sent < 190) ? 81 : 0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (taken) begin
                trace_line(cur_cmd);
                lines_sent++;
            end
            // a beat held against busy stays on the ports untouched
            if (!(start && !taken)) begin
                launch = (line_cmds.size() != 0) && ($urandom_range(99) >= idle_pct);
                if (launch && line_cmds[0].drain_first && pending_pixels.size() != 0)
                    launch = 1'b0;
                if (launch) begin
                    cur_cmd = line_cmds.pop_front();
                    start     <= 1'b1;
                    i_start_x <= cur_cmd.sx;
                    i_start_y <= cur_cmd.sy;
                    i_end_x   <= cur_cmd.ex;
                    i_end_y   <= cur_cmd.ey;
                    i_colour  <= cur_cmd.col;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor: strobe beats are checked against the oldest prediction.
    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_pixel_valid) begin
            if (pending_pixels.size() == 0) begin
                flag_mismatch($sformatf("unexpected pixel (%0d,%0d)", o_pixel_x, o_pixel_y));
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_x !== want.x)
                    flag_mismatch($sformatf("pixel_x %0d, want %0d", o_pixel_x, want.x));
                if (o_pixel_y !== want.y)
                    flag_mismatch($sformatf("pixel_y %0d, want %0d", o_pixel_y, want.y));
                if (o_pixel_colour !== want.col)
                    flag_mismatch($sformatf("pixel_colour %0d, want %0d",
                                            o_pixel_colour, want.col));
                if (o_last_pixel !== want.last)
                    flag_mismatch($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
                                            o_last_pixel, want.last, want.x, want.y));
            end
        end
    end

    task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                            input int col, input bit drain);
        t_line_cmd c;
        c.sx          = t_coord'(sx);
        c.sy          = t_coord'(sy);
        c.ex          = t_coord'(ex);
        c.ey          = t_coord'(ey);
        c.col         = t_colour'(col);
        c.drain_first = drain;
        line_cmds.push_back(c);
    endtask

    // base plus a random offset within +/-span, kept on the 64x64 grid
    function automatic int near(input int base, input int span);
        int v;
        v = base + $urandom_range(2 * span) - span;
        return (v < 0) ? 0 : (v > 63) ? 63 : v;
    endfunction

    // Stimulus and end of run.
    initial begin : stimulus
        int kind, sx, sy, ex, ey, k, kmax, dirx, diry, waited;
        // single points at both corners of the grid and colour range
        add_line(0, 0, 0, 0, 0, 0);
        add_line(63, 63, 63, 63, 255, 0);
        // full-length horizontal and vertical, both directions
        add_line(0, 17, 63, 17, 8'hA5, 0);
        add_line(63, 40, 0, 40, 8'h5A, 0);
        add_line(22, 0, 22, 63, 8'h0F, 0);
        add_line(51, 63, 51, 0, 8'hF0, 0);
        // full diagonals, all four directions
        add_line(0, 0, 63, 63, 1, 0);
        add_line(63, 63, 0, 0, 2, 0);
        add_line(0, 63, 63, 0, 4, 0);
        add_line(63, 0, 0, 63, 8, 0);
        // decision term exactly zero: rising and falling major axis, both majors
        add_line(0, 0, 4, 2, 16, 0);
        add_line(4, 2, 0, 0, 32, 0);
        add_line(0, 0, 2, 4, 64, 0);
        add_line(2, 4, 0, 0, 128, 0);
        // one line in each octant around a common start
        add_line(30, 30, 45, 35, 3, 0);
        add_line(30, 30, 35, 45, 5, 0);
        add_line(30, 30, 25, 45, 6, 0);
        add_line(30, 30, 15, 35, 9, 0);
        add_line(30, 30, 15, 25, 10, 0);
        add_line(30, 30, 25, 15, 12, 0);
        add_line(30, 30, 35, 15, 17, 0);
        add_line(30, 30, 45, 25, 18, 0);
        // shortest slanted lines
        add_line(10, 10, 11, 11, 33, 0);
        add_line(10, 10, 9, 12, 34, 0);

        for (int i = 0; i < 236; i++) begin
            kind = $urandom_range(99);
            sx   = $urandom_range(63);
            sy   = $urandom_range(63);
            if (kind < 50) begin
                ex = near(sx, 6);
                ey = near(sy, 6);
            end else if (kind < 62) begin
                ex = near(sx, 24);
                ey = near(sy, 24);
            end else if (kind < 77) begin
                ex = $urandom_range(63);
                ey = $urandom_range(63);
            end else if (kind < 85) begin
                ex = $urandom_range(63);
                ey = sy;
            end else if (kind < 92) begin
                ex = sx;
                ey = $urandom_range(63);
            end else if (kind < 97) begin
                dirx = $urandom_range(1) ? 1 : -1;
                diry = $urandom_range(1) ? 1 : -1;
                kmax = (dirx > 0) ? 63 - sx : sx;
                k    = (diry > 0) ? 63 - sy : sy;
                if (k < kmax) kmax = k;
                k  = $urandom_range(kmax);
                ex = sx + dirx * k;
                ey = sy + diry * k;
            end else begin
                ex = sx;
                ey = sy;
            end
            // a few beats wait for the pixel stream to drain completely
            add_line(sx, sy, ex, ey, $urandom_range(255), (i == 60 || i == 130 || i == 220));
        end

        wait (i_rst_n === 1'b1);
        while (line_cmds.size() != 0 || start) @(posedge i_clk);
        waited = 0;
        while (pending_pixels.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        // pipeline tail: give a stray pixel time to show up before the final check
        repeat (16) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            flag_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
